### hdl/pgms_pkg.sv
// ----------------------------------------------------------------------------
// pgms_pkg: shared types and constants
// Widths, register indexes, status codes and controller states for the
// process grid chooser.
// ----------------------------------------------------------------------------
`default_nettype none

package pgms_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int STORE_DEPTH = 4096;
	localparam int FIELD_W     = 16;
	localparam int BOX_W       = 20;
	localparam int CFG_ADDR_W  = 2;
	localparam int IN_W        = 64;
	localparam int OUT_W       = 56;

	localparam logic [CFG_ADDR_W-1:0] REG_BOX_LEN_X = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_LEN_Y = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_LEN_Z = 2'd2;

	localparam logic [BOX_W-1:0] BOX_RESET = 20'd256;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_NONE     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_I_TEST,
		S_I_WAIT,
		S_J_TEST,
		S_J_WAIT,
		S_C_RD,
		S_C_CHK,
		S_C_MOVE,
		S_P_RD,
		S_P_LOAD,
		S_P_WAIT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

### hdl/process_grid_min_surface.sv
// ----------------------------------------------------------------------------
// process_grid_min_surface: least-surface 3D process grid chooser
// Lists every ordered factor triple of the count, culls those that break the
// grid constraints, and picks the first triple with the least surface.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one request (count and per-axis wants, 0 = free); it is
//   taken only while the block is idle. m_tdata returns one result per
//   request: the chosen grid and a status (found, none, overflow).
//   Box lengths are written through cfg_we/cfg_addr/cfg_data between jobs.
// Work: dominated by the iterative divider. The listing does one division
//   per candidate i (count of them) plus one per candidate j for every
//   divisor i, so n + sum of n/i over the divisors i of n divisions in all.
//   Culling tests each stored entry in turn; scoring runs once per survivor.
// Throughput: one request at a time.
// Reset: box lengths return to 1.0 (256); the store holds no valid data and
//   needs no clearing, each entry is written before it is read.
// Stall: a finished result sits in the output register while m_tready is low;
//   the next request is still accepted, but its result is held back until
//   the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module process_grid_min_surface #(
	parameter int COUNT_BITS  = pgms_pkg::COUNT_BITS,
	parameter int STORE_DEPTH = pgms_pkg::STORE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pgms_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [pgms_pkg::BOX_W-1:0]      cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// proc_count[15:0], want_x[31:16], want_y[47:32], want_z[63:48]
	input  wire logic [pgms_pkg::IN_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// grid_x[15:0], grid_y[31:16], grid_z[47:32], status[49:48], zero above
	output logic [pgms_pkg::OUT_W-1:0]           m_tdata
);

	localparam int CB = COUNT_BITS;
	localparam int FW = pgms_pkg::FIELD_W;
	localparam int BW = pgms_pkg::BOX_W;
	localparam int EW = 3 * CB;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int SW = 2 * BW + CB + 2;
	localparam int CW = (CB > FW) ? CB : FW;

	pgms_pkg::state_t state_q, state_d;

	logic [BW-1:0]   box_x_q, box_y_q, box_z_q;
	logic [2*BW-1:0] area_xy_q, area_xz_q, area_yz_q;
	logic            area_nz;

	logic [CB-1:0] n_q;
	logic [FW-1:0] want_q [3];
	logic [CB:0]   i_q, j_q;
	logic [CB-1:0] q_q;
	logic [AW:0]   cnt_q, s_q;
	logic          found_q, ovf_q;
	logic [SW-1:0] best_q;
	logic [EW-1:0] bestt_q;

	logic          m_tvalid_q;
	logic [FW-1:0] grid_x_q, grid_y_q, grid_z_q;
	pgms_pkg::status_t status_q;

	logic          div_start, div_done;
	logic [CB-1:0] div_a, div_b, div_quot, div_rem;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic          score_start, score_done;
	logic [SW-1:0] score;

	logic i_over, j_over, s_end, s_last, bad, take, accept, out_free, full;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= pgms_pkg::BOX_RESET;
			box_y_q <= pgms_pkg::BOX_RESET;
			box_z_q <= pgms_pkg::BOX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pgms_pkg::REG_BOX_LEN_X: box_x_q <= cfg_data;
				pgms_pkg::REG_BOX_LEN_Y: box_y_q <= cfg_data;
				pgms_pkg::REG_BOX_LEN_Z: box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the user must change lengths only between jobs, which the block does not check; the areas are simply re-registered
	always_ff @(posedge clk) begin
		area_xy_q <= (2*BW)'(box_x_q) * (2*BW)'(box_y_q);
		area_xz_q <= (2*BW)'(box_x_q) * (2*BW)'(box_z_q);
		area_yz_q <= (2*BW)'(box_y_q) * (2*BW)'(box_z_q);
	end

	assign area_nz = (area_xy_q | area_xz_q | area_yz_q) != '0;

	pgms_div #(.W(CB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	pgms_store #(.DEPTH(STORE_DEPTH), .W(EW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pgms_score #(.CB(CB), .BW(BW)) u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (score_start),
		.area_xy (area_xy_q),
		.area_xz (area_xz_q),
		.area_yz (area_yz_q),
		.triple  (mem_rdata),
		.done    (score_done),
		.score   (score)
	);

	assign i_over   = i_q > {1'b0, n_q};
	assign j_over   = j_q > {1'b0, q_q};
	assign s_end    = s_q == cnt_q;
	assign s_last   = s_q == (cnt_q - 1'b1);
	assign full     = cnt_q == (AW+1)'(STORE_DEPTH);
	assign take     = found_q ? (score < best_q) : area_nz;
	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		bad = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (want_q[a] != '0 && CW'(mem_rdata[a*CB +: CB]) != CW'(want_q[a])) begin
				bad = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgms_pkg::S_IDLE:   if (s_tvalid) state_d = pgms_pkg::S_I_TEST;
			pgms_pkg::S_I_TEST: state_d = i_over ? pgms_pkg::S_C_RD : pgms_pkg::S_I_WAIT;
			pgms_pkg::S_I_WAIT: begin
				if (div_done) begin
					state_d = (div_rem != '0) ? pgms_pkg::S_I_TEST : pgms_pkg::S_J_TEST;
				end
			end
			pgms_pkg::S_J_TEST: state_d = j_over ? pgms_pkg::S_I_TEST : pgms_pkg::S_J_WAIT;
			pgms_pkg::S_J_WAIT: begin
				if (div_done) begin
					state_d = (div_rem == '0 && full) ? pgms_pkg::S_RESULT
						: pgms_pkg::S_J_TEST;
				end
			end
			pgms_pkg::S_C_RD:   state_d = s_end ? pgms_pkg::S_P_RD : pgms_pkg::S_C_CHK;
			pgms_pkg::S_C_CHK: begin
				if (!bad || s_last) state_d = pgms_pkg::S_C_RD;
				else state_d = pgms_pkg::S_C_MOVE;
			end
			pgms_pkg::S_C_MOVE: state_d = pgms_pkg::S_C_CHK;
			pgms_pkg::S_P_RD:   state_d = s_end ? pgms_pkg::S_RESULT : pgms_pkg::S_P_LOAD;
			pgms_pkg::S_P_LOAD: state_d = pgms_pkg::S_P_WAIT;
			pgms_pkg::S_P_WAIT: if (score_done) state_d = pgms_pkg::S_P_RD;
			pgms_pkg::S_RESULT: if (out_free) state_d = pgms_pkg::S_IDLE;
			default:            state_d = pgms_pkg::S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_tready    = state_q == pgms_pkg::S_IDLE;
		div_start   = 1'b0;
		div_a       = n_q;
		div_b       = i_q[CB-1:0];
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[AW-1:0];
		mem_wdata   = {div_quot, j_q[CB-1:0], i_q[CB-1:0]};
		mem_re      = 1'b0;
		mem_raddr   = s_q[AW-1:0];
		score_start = 1'b0;
		unique case (state_q)
			pgms_pkg::S_I_TEST: div_start = !i_over;
			pgms_pkg::S_J_TEST: begin
				div_start = !j_over;
				div_a     = q_q;
				div_b     = j_q[CB-1:0];
			end
			pgms_pkg::S_J_WAIT: mem_we = div_done && div_rem == '0 && !full;
			pgms_pkg::S_C_RD:   mem_re = !s_end;
			pgms_pkg::S_C_CHK: begin
				mem_re    = bad && !s_last;
				mem_raddr = cnt_q[AW-1:0] - 1'b1;
			end
			pgms_pkg::S_C_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = s_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			pgms_pkg::S_P_RD:   mem_re = !s_end;
			pgms_pkg::S_P_LOAD: score_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pgms_pkg::S_IDLE;
			cnt_q      <= '0;
			s_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			found_q    <= 1'b0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pgms_pkg::S_RESULT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				pgms_pkg::S_IDLE: begin
					if (accept) begin
						i_q     <= (CB+1)'(1);
						cnt_q   <= '0;
						s_q     <= '0;
						found_q <= 1'b0;
						ovf_q   <= 1'b0;
					end
				end
				pgms_pkg::S_I_WAIT: begin
					if (div_done) begin
						if (div_rem != '0) i_q <= i_q + 1'b1;
						else j_q <= (CB+1)'(1);
					end
				end
				pgms_pkg::S_J_TEST: if (j_over) i_q <= i_q + 1'b1;
				pgms_pkg::S_J_WAIT: begin
					if (div_done) begin
						j_q <= j_q + 1'b1;
						if (div_rem == '0) begin
							if (full) ovf_q <= 1'b1;
							else cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				pgms_pkg::S_C_RD: if (s_end) s_q <= '0;
				pgms_pkg::S_C_CHK: begin
					if (bad) cnt_q <= cnt_q - 1'b1;
					else s_q <= s_q + 1'b1;
				end
				pgms_pkg::S_P_WAIT: begin
					if (score_done) begin
						s_q <= s_q + 1'b1;
						if (take) found_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q       <= CB'(s_tdata[FW-1:0]);
			want_q[0] <= s_tdata[FW +: FW];
			want_q[1] <= s_tdata[2*FW +: FW];
			want_q[2] <= s_tdata[3*FW +: FW];
		end
		if (state_q == pgms_pkg::S_I_WAIT && div_done) q_q <= div_quot;
		if (state_q == pgms_pkg::S_P_WAIT && score_done && take) begin
			best_q  <= score;
			bestt_q <= mem_rdata;
		end
		if (state_q == pgms_pkg::S_RESULT && out_free) begin
			if (ovf_q) begin
				status_q <= pgms_pkg::ST_OVERFLOW;
			end else if (found_q) begin
				status_q <= pgms_pkg::ST_FOUND;
			end else begin
				status_q <= pgms_pkg::ST_NONE;
			end
			if (found_q && !ovf_q) begin
				grid_x_q <= FW'(bestt_q[0 +: CB]);
				grid_y_q <= FW'(bestt_q[CB +: CB]);
				grid_z_q <= FW'(bestt_q[2*CB +: CB]);
			end else begin
				grid_x_q <= '0;
				grid_y_q <= '0;
				grid_z_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, status_q, grid_z_q, grid_y_q, grid_x_q};

	// assertions
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(STORE_DEPTH))
		else $error("triple count beyond store depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pgms_pkg::S_C_CHK || state_q == pgms_pkg::S_C_MOVE) |-> s_q < cnt_q)
		else $error("cull scan past live entries");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == pgms_pkg::S_I_WAIT || state_q == pgms_pkg::S_J_WAIT))
		else $error("divider result with no pending division");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == pgms_pkg::S_J_WAIT) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("listing write did not advance count");

endmodule

`default_nettype wire

### hdl/pgms_div.sv
// ----------------------------------------------------------------------------
// pgms_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when quot and
// rem are valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pgms_div #(
	parameter int W = pgms_pkg::COUNT_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[W] ? shifted : diff;
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q[W-1:0];

endmodule

`default_nettype wire

### hdl/pgms_store.sv
// ----------------------------------------------------------------------------
// pgms_store: triple scratch memory
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pgms_store #(
	parameter int DEPTH = pgms_pkg::STORE_DEPTH,
	parameter int W     = 3 * pgms_pkg::COUNT_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]                  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/pgms_score.sv
// ----------------------------------------------------------------------------
// pgms_score: scaled surface of one triple
// xy*k + xz*j + yz*i, one half-area partial product a cycle through one
// multiplier, each product registered and accumulated in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pgms_score #(
	parameter int CB = pgms_pkg::COUNT_BITS,
	parameter int BW = pgms_pkg::BOX_W
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*BW-1:0]       area_xy,
	input  wire logic [2*BW-1:0]       area_xz,
	input  wire logic [2*BW-1:0]       area_yz,
	input  wire logic [3*CB-1:0]       triple,
	output logic                       done,
	output logic [2*BW+CB+1:0]         score
);

	localparam int SW = 2 * BW + CB + 2;
	localparam int PW = BW + CB;

	logic          busy_q;
	logic [2:0]    step_q;
	logic          done_q;
	logic [PW-1:0] pp_s1;
	logic          ppv_s1;
	logic          hi_s1;
	logic          last_s1;
	logic [SW-1:0] acc_q;
	logic [2*BW-1:0] area_sel;
	logic [CB-1:0]   size_sel;
	logic [BW-1:0]   half_sel;

	always_comb begin
		case (step_q[2:1])
			2'd0: begin
				area_sel = area_xy;
				size_sel = triple[2*CB +: CB];
			end
			2'd1: begin
				area_sel = area_xz;
				size_sel = triple[CB +: CB];
			end
			default: begin
				area_sel = area_yz;
				size_sel = triple[0 +: CB];
			end
		endcase
		half_sel = step_q[0] ? area_sel[2*BW-1:BW] : area_sel[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			ppv_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ppv_s1 && last_s1;
			ppv_s1 <= busy_q;
			last_s1 <= busy_q && (step_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= PW'(half_sel) * PW'(size_sel);
		hi_s1 <= step_q[0];
		if (start) begin
			acc_q <= '0;
		end else if (ppv_s1) begin
			acc_q <= acc_q + (hi_s1 ? (SW'(pp_s1) << BW) : SW'(pp_s1));
		end
	end

	assign done  = done_q;
	assign score = acc_q;

endmodule

`default_nettype wire

### bench/tb_process_grid_min_surface.sv
// ----------------------------------------------------------------------------
// tb_process_grid_min_surface: self-checking bench for the grid chooser
// Sends grid requests over the slave stream and checks each result against
// an in-bench predictor. The predictor lists the factor triples, culls them
// with the swap-with-last rule and picks the first one with the least surface.
// Box lengths are changed between phases while the block is idle. Both
// stream sides idle at random, with one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_process_grid_min_surface;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [pgms_pkg::FIELD_W-1:0] grid_x;
		logic [pgms_pkg::FIELD_W-1:0] grid_y;
		logic [pgms_pkg::FIELD_W-1:0] grid_z;
		pgms_pkg::status_t            status;
	} grid_result_t;

	class grid_scoreboard;
		grid_result_t                 expected_q[$];
		int                           fail_count;
		logic [pgms_pkg::BOX_W-1:0]   len_x, len_y, len_z;

		function new();
			fail_count = 0;
			len_x = pgms_pkg::BOX_RESET;
			len_y = pgms_pkg::BOX_RESET;
			len_z = pgms_pkg::BOX_RESET;
		endfunction

		function void set_boxes(logic [pgms_pkg::BOX_W-1:0] bx,
				logic [pgms_pkg::BOX_W-1:0] by, logic [pgms_pkg::BOX_W-1:0] bz);
			len_x = bx;
			len_y = by;
			len_z = bz;
		endfunction

		// list, cull, then score the triples of one request
		function grid_result_t choose_grid(logic [pgms_pkg::FIELD_W-1:0] count,
				logic [pgms_pkg::FIELD_W-1:0] wx, logic [pgms_pkg::FIELD_W-1:0] wy,
				logic [pgms_pkg::FIELD_W-1:0] wz);
			int unsigned  tx[$], ty[$], tz[$];
			int unsigned  n, q, cnt, s;
			bit           overflow, found, bad;
			logic [63:0]  axy, axz, ayz, score, best;
			grid_result_t r;
			n = count & ((1 << pgms_pkg::COUNT_BITS) - 1);
			overflow = 0;
			found = 0;
			best = '0;
			r.grid_x = '0;
			r.grid_y = '0;
			r.grid_z = '0;
			for (int unsigned i = 1; i <= n && !overflow; i++) begin
				if (n % i != 0)
					continue;
				q = n / i;
				for (int unsigned j = 1; j <= q; j++) begin
					if (q % j != 0)
						continue;
					if (tx.size() >= pgms_pkg::STORE_DEPTH) begin
						overflow = 1;
						break;
					end
					tx.push_back(i);
					ty.push_back(j);
					tz.push_back(q / j);
				end
			end
			if (overflow) begin
				r.status = pgms_pkg::ST_OVERFLOW;
				return r;
			end
			cnt = tx.size();
			s = 0;
			while (s < cnt) begin
				bad = (wx != 0 && tx[s] != wx) || (wy != 0 && ty[s] != wy) ||
					(wz != 0 && tz[s] != wz);
				if (bad) begin
					tx[s] = tx[cnt-1];
					ty[s] = ty[cnt-1];
					tz[s] = tz[cnt-1];
					cnt--;
				end else begin
					s++;
				end
			end
			axy = 64'(len_x) * 64'(len_y);
			axz = 64'(len_x) * 64'(len_z);
			ayz = 64'(len_y) * 64'(len_z);
			for (s = 0; s < cnt; s++) begin
				score = axy * 64'(tz[s]) + axz * 64'(ty[s]) + ayz * 64'(tx[s]);
				if (found ? (score < best) : ((axy | axz | ayz) != 0)) begin
					found = 1;
					best = score;
					r.grid_x = tx[s][pgms_pkg::FIELD_W-1:0];
					r.grid_y = ty[s][pgms_pkg::FIELD_W-1:0];
					r.grid_z = tz[s][pgms_pkg::FIELD_W-1:0];
				end
			end
			if (!found) begin
				r.grid_x = '0;
				r.grid_y = '0;
				r.grid_z = '0;
				r.status = pgms_pkg::ST_NONE;
			end else begin
				r.status = pgms_pkg::ST_FOUND;
			end
			return r;
		endfunction

		function void note_request(logic [pgms_pkg::IN_W-1:0] req);
			expected_q.push_back(choose_grid(req[15:0], req[31:16], req[47:32],
				req[63:48]));
		endfunction

		function void check_result(logic [pgms_pkg::OUT_W-1:0] data);
			grid_result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: %h", data);
				fail_count++;
				return;
			end
			e = expected_q.pop_front();
			if (data[15:0] !== e.grid_x) begin
				$error("grid_x: expected %0d, got %0d", e.grid_x, data[15:0]);
				fail_count++;
			end
			if (data[31:16] !== e.grid_y) begin
				$error("grid_y: expected %0d, got %0d", e.grid_y, data[31:16]);
				fail_count++;
			end
			if (data[47:32] !== e.grid_z) begin
				$error("grid_z: expected %0d, got %0d", e.grid_z, data[47:32]);
				fail_count++;
			end
			if (data[49:48] !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, data[49:48]);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [pgms_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [pgms_pkg::BOX_W-1:0]      cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [pgms_pkg::IN_W-1:0]       s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [pgms_pkg::OUT_W-1:0]      m_tdata;

	grid_scoreboard sb = new();
	bit             no_gaps = 0;
	bit             hold_req = 0;

	process_grid_min_surface DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	initial begin
		#2_000_000_000;
		$display("tb_process_grid_min_surface: done, errors");
		$finish;
	end

	// result side: check, then pick next tready; long hold counted here
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_req) begin
				hold_req = 0;
				hold_left = 20000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 25);
			end
		end
	end

	task automatic write_boxes(logic [pgms_pkg::BOX_W-1:0] bx,
			logic [pgms_pkg::BOX_W-1:0] by, logic [pgms_pkg::BOX_W-1:0] bz);
		logic [pgms_pkg::BOX_W-1:0] v[3];
		logic [pgms_pkg::CFG_ADDR_W-1:0] a[3];
		v = '{bx, by, bz};
		a = '{pgms_pkg::REG_BOX_LEN_X, pgms_pkg::REG_BOX_LEN_Y, pgms_pkg::REG_BOX_LEN_Z};
		for (int r = 0; r < 3; r++) begin
			cfg_we <= 1'b1;
			cfg_addr <= a[r];
			cfg_data <= v[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sb.set_boxes(bx, by, bz);
	endtask

	task automatic send_request(logic [15:0] n, logic [15:0] wx, logic [15:0] wy,
			logic [15:0] wz);
		while (!no_gaps && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wz, wy, wx, n};
		do @(posedge clk); while (!s_tready);
		sb.note_request({wz, wy, wx, n});
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mostly small counts; wants follow a real triple, are random or are left free
	task automatic send_random();
		logic [15:0] n, w[3];
		int unsigned i, j, q, pick, roll;
		roll = $urandom_range(99);
		if (roll < 3)
			n = 16'd0;
		else if (roll < 13)
			n = 16'($urandom_range(1023, 1));
		else
			n = 16'($urandom_range(255, 1));
		w = '{16'd0, 16'd0, 16'd0};
		roll = $urandom_range(99);
		if (n != 0 && roll < 70) begin
			do i = $urandom_range(n, 1); while (n % i != 0);
			q = n / i;
			do j = $urandom_range(q, 1); while (q % j != 0);
			pick = $urandom_range(7);
			if (pick[0]) w[0] = 16'(i);
			if (pick[1]) w[1] = 16'(j);
			if (pick[2]) w[2] = 16'(q / j);
		end else if (roll < 85) begin
			for (int a = 0; a < 3; a++)
				if ($urandom_range(1))
					w[a] = 16'($urandom_range(65535));
		end
		send_request(n, w[0], w[1], w[2]);
	endtask

	initial begin
		logic [pgms_pkg::BOX_W-1:0] rx, ry, rz;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset box lengths
		send_request(16'd1, 16'd0, 16'd0, 16'd0);
		send_request(16'd0, 16'd0, 16'd0, 16'd0);
		send_request(16'd12, 16'd2, 16'd0, 16'd0);
		send_request(16'd12, 16'd5, 16'd0, 16'd0);
		send_request(16'd64, 16'd4, 16'd4, 16'd4);
		send_request(16'd60, 16'd0, 16'd0, 16'd60);
		send_request(16'd36, 16'd0, 16'd3, 16'd0);
		send_request(16'd30, 16'd65535, 16'd65535, 16'd65535);
		send_request(16'd24, 16'd2, 16'd3, 16'd5);
		send_request(16'd65535, 16'd0, 16'd0, 16'd0);
		wait_idle();

		// widest lengths, skewed box
		write_boxes(20'hFFFFF, 20'd1, 20'hFFFFF);
		send_request(16'd48, 16'd0, 16'd0, 16'd0);
		send_request(16'd720, 16'd0, 16'd0, 16'd0);
		send_request(16'd97, 16'd0, 16'd0, 16'd0);
		wait_idle();
		write_boxes(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_request(16'd1000, 16'd0, 16'd0, 16'd0);
		send_request(16'd96, 16'd0, 16'd8, 16'd0);
		wait_idle();

		// zero areas: nothing qualifies, then one nonzero area
		write_boxes(20'd0, 20'd0, 20'd0);
		send_request(16'd8, 16'd0, 16'd0, 16'd0);
		wait_idle();
		write_boxes(20'd0, 20'd5, 20'd7);
		send_request(16'd8, 16'd0, 16'd0, 16'd0);
		send_request(16'd18, 16'd0, 16'd0, 16'd0);
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			rx = pgms_pkg::BOX_W'($urandom_range(20'hFFFFF, 1));
			ry = pgms_pkg::BOX_W'($urandom_range(20'hFFFFF, 1));
			rz = pgms_pkg::BOX_W'($urandom_range(20'hFFFFF, 1));
			if (phase == 1) begin
				ry = pgms_pkg::BOX_W'($urandom_range(300, 1));
				rz = 20'd1;
			end
			write_boxes(rx, ry, rz);
			no_gaps = (phase == 2);
			if (phase == 3)
				hold_req = 1;
			for (int k = 0; k < 16; k++)
				send_random();
			wait_idle();
		end
		no_gaps = 0;

		if (sb.fail_count == 0)
			$display("tb_process_grid_min_surface: done, clean");
		else
			$display("tb_process_grid_min_surface: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
